// ===== hdl/rv32i_instruction_encoder_macros.svh =====
// Assertion macros for the encoder RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef RV32I_INSTRUCTION_ENCODER_MACROS_SVH
`define RV32I_INSTRUCTION_ENCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define RVIE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define RVIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rvie_pkg.sv =====
// Shared types, opcode constants and the mnemonic table of the RV32I encoder.
// No dependencies; imported by every module of the block.
package rvie_pkg;

	localparam int unsigned MN_COUNT = 30;

	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [31:0] ADDR_STEP = 32'd4;

	// FMT_RAW: raw text word, FMT_NONE: unused mnemonic code
	typedef enum logic [3:0] {
		FMT_R, FMT_I, FMT_L, FMT_S, FMT_B, FMT_J, FMT_U, FMT_RAW, FMT_NONE
	} fmt_t;

	typedef struct packed {
		fmt_t       fmt;
		logic [6:0] opcode;
		logic [2:0] funct3;
		logic [6:0] funct7;
	} op_entry_t;

	typedef struct packed {
		logic               mode;
		logic [4:0]         mnemonic;
		logic [4:0]         rd;
		logic [4:0]         rs1;
		logic [4:0]         rs2;
		logic signed [31:0] imm;
		logic               target_known;
		logic [31:0]        target_address;
	} in_t;

	typedef struct packed {
		logic [31:0] instruction_word;
		logic [31:0] instruction_address;
		logic        needs_relocation;
		logic        relocation_kind;
		logic        imm_out_of_range;
	} out_t;

	// classified transaction held between front and back
	typedef struct packed {
		fmt_t        fmt;
		logic [6:0]  opcode;
		logic [2:0]  funct3;
		logic [6:0]  funct7;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [31:0] imm;
		logic [19:0] off;    // branch/jump offset bits 20:1
		logic [31:0] addr;
		logic        reloc;
		logic        kind;
		logic        warn;
	} ent_t;

	localparam op_entry_t OP_TABLE [MN_COUNT] = '{
		'{FMT_R, OPC_OP, 3'h0, F7_BASE}, '{FMT_R, OPC_OP, 3'h0, F7_ALT},
		'{FMT_R, OPC_OP, 3'h1, F7_BASE}, '{FMT_R, OPC_OP, 3'h4, F7_BASE},
		'{FMT_R, OPC_OP, 3'h5, F7_BASE}, '{FMT_R, OPC_OP, 3'h5, F7_ALT},
		'{FMT_R, OPC_OP, 3'h6, F7_BASE}, '{FMT_R, OPC_OP, 3'h7, F7_BASE},
		'{FMT_I, OPC_OP_IMM, 3'h0, F7_BASE}, '{FMT_I, OPC_OP_IMM, 3'h4, F7_BASE},
		'{FMT_I, OPC_OP_IMM, 3'h6, F7_BASE}, '{FMT_I, OPC_OP_IMM, 3'h7, F7_BASE},
		'{FMT_I, OPC_OP_IMM, 3'h1, F7_BASE}, '{FMT_I, OPC_OP_IMM, 3'h5, F7_BASE},
		'{FMT_I, OPC_OP_IMM, 3'h5, F7_ALT},  '{FMT_I, OPC_OP_IMM, 3'h2, F7_BASE},
		'{FMT_L, OPC_LOAD, 3'h0, F7_BASE}, '{FMT_L, OPC_LOAD, 3'h1, F7_BASE},
		'{FMT_L, OPC_LOAD, 3'h2, F7_BASE},
		'{FMT_S, OPC_STORE, 3'h0, F7_BASE}, '{FMT_S, OPC_STORE, 3'h1, F7_BASE},
		'{FMT_S, OPC_STORE, 3'h2, F7_BASE},
		'{FMT_B, OPC_BRANCH, 3'h0, F7_BASE}, '{FMT_B, OPC_BRANCH, 3'h1, F7_BASE},
		'{FMT_B, OPC_BRANCH, 3'h4, F7_BASE}, '{FMT_B, OPC_BRANCH, 3'h5, F7_BASE},
		'{FMT_J, OPC_JAL, 3'h0, F7_BASE},
		'{FMT_L, OPC_JALR, 3'h0, F7_BASE},
		'{FMT_U, OPC_LUI, 3'h0, F7_BASE}, '{FMT_U, OPC_AUIPC, 3'h0, F7_BASE}
	};

endpackage

// ===== hdl/rv32i_instruction_encoder.sv =====
// Channel  | Dir | Handshake                 | Payload
// item     | in  | item_valid / item_stall   | rvie_pkg::in_t  (one instruction or raw word)
// result   | out | result_valid/result_stall | rvie_pkg::out_t (machine word and flags)
// One transaction per cycle while result_stall is low; each is queued, then registered.
// The front end assigns the text address and offset; a two-entry queue decouples it from
// the back end, whose output register holds the packed word.
// Reset clears the address counter to zero, empties the queue and drops result_valid.
// A stall on the result side fills the queue; item_stall rises once both entries are held.
// Top level: depends on rvie_pkg, rvie_front, rvie_queue and rvie_back.
module rv32i_instruction_encoder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  rvie_pkg::in_t  item,
	output logic           result_valid,
	input  logic           result_stall,
	output rvie_pkg::out_t result
);
	import rvie_pkg::*;

	logic push, pop, q_full, q_empty;
	ent_t push_ent, pop_ent;

	rvie_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.push_ent   (push_ent)
	);

	rvie_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.pop_ent  (pop_ent),
		.full     (q_full),
		.empty    (q_empty)
	);

	rvie_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.pop_ent      (pop_ent),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== hdl/rvie_front.sv =====
// Front end: accepts transactions, looks up the mnemonic, assigns the text
// address and resolves branch/jump offsets. Depends on rvie_pkg.
module rvie_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  rvie_pkg::in_t      item,
	input  logic               q_full,
	output logic               push,
	output rvie_pkg::ent_t     push_ent
);
	import rvie_pkg::*;

	logic [31:0] addr_q;
	logic [31:0] diff;
	op_entry_t   e;
	logic        is_b, is_j, is_imm12, imm_oor;

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (push) begin
			addr_q <= addr_q + ADDR_STEP;
		end
	end

	assign diff = item.target_address - addr_q;
	// in range iff imm[31:11] is a pure sign extension
	assign imm_oor = !((&item.imm[31:11]) || !(|item.imm[31:11]));

	always_comb begin
		e = OP_TABLE[item.mnemonic];
		push_ent.opcode = e.opcode;
		push_ent.funct3 = e.funct3;
		push_ent.funct7 = e.funct7;
		if (item.mode) begin
			push_ent.fmt = FMT_RAW;
		end else if (32'(item.mnemonic) < MN_COUNT) begin
			push_ent.fmt = e.fmt;
		end else begin
			push_ent.fmt = FMT_NONE;
		end
		is_b     = (push_ent.fmt == FMT_B);
		is_j     = (push_ent.fmt == FMT_J);
		is_imm12 = (push_ent.fmt == FMT_I) || (push_ent.fmt == FMT_L) ||
			(push_ent.fmt == FMT_S);
		push_ent.rd    = item.rd;
		push_ent.rs1   = item.rs1;
		push_ent.rs2   = item.rs2;
		push_ent.imm   = item.imm;
		push_ent.addr  = addr_q;
		push_ent.off   = item.target_known ? diff[20:1] : '0;
		push_ent.reloc = (is_b || is_j) && !item.target_known;
		push_ent.kind  = is_j && !item.target_known;
		push_ent.warn  = is_imm12 && imm_oor;
	end

endmodule

// ===== hdl/rvie_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on rvie_pkg and the assertion macro header.
`include "rv32i_instruction_encoder_macros.svh"

module rvie_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rvie_pkg::ent_t push_ent,
	input  logic           pop,
	output rvie_pkg::ent_t pop_ent,
	output logic           full,
	output logic           empty
);
	import rvie_pkg::*;

	ent_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign pop_ent = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`RVIE_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q != 2'd3, "queue count overran")
	`RVIE_ASSERT_NOW(a_no_pop_empty, clk, arst_n, empty, !pop, "pop from empty queue")
	`RVIE_ASSERT_NOW(a_no_push_full, clk, arst_n, full, !push, "push into full queue")
	`RVIE_ASSERT_NEXT(a_push_grow, clk, arst_n, push && !pop, count_q == $past(count_q) + 2'd1, "count did not grow")

endmodule

// ===== hdl/rvie_back.sv =====
// Back end: packs the classified transaction into the machine word and holds
// it in the output register. Depends on rvie_pkg.
module rvie_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  rvie_pkg::ent_t pop_ent,
	output logic           pop,
	output logic           result_valid,
	input  logic           result_stall,
	output rvie_pkg::out_t result
);
	import rvie_pkg::*;

	logic        valid_q;
	out_t        result_q;
	logic [31:0] word;
	ent_t        x;

	assign x   = pop_ent;
	assign pop = !q_empty && (!valid_q || !result_stall);

	always_comb begin
		unique case (x.fmt)
			FMT_R:   word = {x.funct7, x.rs2, x.rs1, x.funct3, x.rd, x.opcode};
			// shift immediates OR funct7 over imm[11:5]
			FMT_I, FMT_L: word = {x.imm[11:5] | x.funct7, x.imm[4:0], x.rs1, x.funct3,
				x.rd, x.opcode};
			FMT_S:   word = {x.imm[11:5], x.rs2, x.rs1, x.funct3, x.imm[4:0], x.opcode};
			FMT_B:   word = {x.off[11], x.off[9:4], x.rs2, x.rs1, x.funct3, x.off[3:0],
				x.off[10], x.opcode};
			FMT_J:   word = {x.off[19], x.off[9:0], x.off[10], x.off[18:11], x.rd,
				x.opcode};
			FMT_U:   word = {x.imm[19:0], x.rd, x.opcode};
			FMT_RAW: word = x.imm;
			FMT_NONE: word = '0;
			default: word = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !result_stall) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.instruction_word    <= word;
			result_q.instruction_address <= x.addr;
			result_q.needs_relocation    <= x.reloc;
			result_q.relocation_kind     <= x.kind;
			result_q.imm_out_of_range    <= x.warn;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for rv32i_instruction_encoder: random and directed RV32I items,
// with the expected machine words predicted inside the bench and checked against each result.
// Depends on rvie_pkg (payload types, format enum, opcode constants) and the encoder RTL.
module tb_top;
	import rvie_pkg::*;

	typedef enum logic [4:0] {
		MN_ADD, MN_SUB, MN_SLL, MN_XOR, MN_SRL, MN_SRA, MN_OR, MN_AND,
		MN_ADDI, MN_XORI, MN_ORI, MN_ANDI, MN_SLLI, MN_SRLI, MN_SRAI, MN_SLTI,
		MN_LB, MN_LH, MN_LW, MN_SB, MN_SH, MN_SW,
		MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_JAL, MN_JALR, MN_LUI, MN_AUIPC,
		MN_UNUSED0, MN_UNUSED1
	} mnemonic_e;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_RAW    = 1'b1;
	localparam logic REL_BRANCH  = 1'b0;
	localparam logic REL_JUMP    = 1'b1;

	localparam op_entry_t ENCODING_TABLE [MN_COUNT] = '{
		'{FMT_R, OPC_OP, 3'h0, F7_BASE}, '{FMT_R, OPC_OP, 3'h0, F7_ALT},
		'{FMT_R, OPC_OP, 3'h1, F7_BASE}, '{FMT_R, OPC_OP, 3'h4, F7_BASE},
		'{FMT_R, OPC_OP, 3'h5, F7_BASE}, '{FMT_R, OPC_OP, 3'h5, F7_ALT},
		'{FMT_R, OPC_OP, 3'h6, F7_BASE}, '{FMT_R, OPC_OP, 3'h7, F7_BASE},
		'{FMT_I, OPC_OP_IMM, 3'h0, F7_BASE}, '{FMT_I, OPC_OP_IMM, 3'h4, F7_BASE},
		'{FMT_I, OPC_OP_IMM, 3'h6, F7_BASE}, '{FMT_I, OPC_OP_IMM, 3'h7, F7_BASE},
		'{FMT_I, OPC_OP_IMM, 3'h1, F7_BASE}, '{FMT_I, OPC_OP_IMM, 3'h5, F7_BASE},
		'{FMT_I, OPC_OP_IMM, 3'h5, F7_ALT},  '{FMT_I, OPC_OP_IMM, 3'h2, F7_BASE},
		'{FMT_L, OPC_LOAD, 3'h0, F7_BASE}, '{FMT_L, OPC_LOAD, 3'h1, F7_BASE},
		'{FMT_L, OPC_LOAD, 3'h2, F7_BASE},
		'{FMT_S, OPC_STORE, 3'h0, F7_BASE}, '{FMT_S, OPC_STORE, 3'h1, F7_BASE},
		'{FMT_S, OPC_STORE, 3'h2, F7_BASE},
		'{FMT_B, OPC_BRANCH, 3'h0, F7_BASE}, '{FMT_B, OPC_BRANCH, 3'h1, F7_BASE},
		'{FMT_B, OPC_BRANCH, 3'h4, F7_BASE}, '{FMT_B, OPC_BRANCH, 3'h5, F7_BASE},
		'{FMT_J, OPC_JAL, 3'h0, F7_BASE},
		'{FMT_L, OPC_JALR, 3'h0, F7_BASE},
		'{FMT_U, OPC_LUI, 3'h0, F7_BASE}, '{FMT_U, OPC_AUIPC, 3'h0, F7_BASE}
	};

	// -2049, -2048, 2047, 2048, 0, -1, most negative, most positive
	localparam logic [31:0] IMM_EDGES [8] = '{
		32'hFFFF_F7FF, 32'hFFFF_F800, 32'h0000_07FF, 32'h0000_0800,
		32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF
	};

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_stall;
	in_t   item = '0;
	logic  result_valid;
	logic  result_stall = 1'b0;
	out_t  result;

	in_t          pending_items [$];
	out_t         expected_results [$];
	logic [31:0]  encode_address = '0;   // text address of the next accepted transaction
	logic [31:0]  plan_address = '0;     // text address the next queued item will land at
	int unsigned  sender_idle_pct = 0;
	int unsigned  receiver_stall_pct = 0;
	logic         hold_results = 1'b0;
	int unsigned  mismatch_count = 0;

	rv32i_instruction_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #4 clk = ~clk;

	function automatic out_t encode_instruction(input in_t it, input logic [31:0] pc);
		out_t        res;
		op_entry_t   e;
		logic [31:0] imm;
		logic [31:0] off;
		logic        imm_wide;
		res = '0;
		imm = it.imm;
		off = '0;
		imm_wide = ($signed(imm) < -2048) || ($signed(imm) > 2047);
		res.instruction_address = pc;
		if (it.mode == MODE_RAW) begin
			res.instruction_word = imm;
		end else if (it.mnemonic < MN_COUNT) begin
			e = ENCODING_TABLE[it.mnemonic];
			if (e.fmt == FMT_B || e.fmt == FMT_J) begin
				if (it.target_known)
					off = it.target_address - pc;
				else begin
					res.needs_relocation = 1'b1;
					res.relocation_kind = (e.fmt == FMT_J) ? REL_JUMP : REL_BRANCH;
				end
			end
			case (e.fmt)
				FMT_R: res.instruction_word = {e.funct7, it.rs2, it.rs1, e.funct3, it.rd, e.opcode};
				FMT_I: begin
					res.imm_out_of_range = imm_wide;
					res.instruction_word = {imm[11:0], it.rs1, e.funct3, it.rd, e.opcode};
					// shift-immediate funct7 is ORed over the top of the immediate
					res.instruction_word[31:25] = res.instruction_word[31:25] | e.funct7;
				end
				FMT_L: begin
					res.imm_out_of_range = imm_wide;
					res.instruction_word = {imm[11:0], it.rs1, e.funct3, it.rd, e.opcode};
				end
				FMT_S: begin
					res.imm_out_of_range = imm_wide;
					res.instruction_word = {imm[11:5], it.rs2, it.rs1, e.funct3, imm[4:0],
						e.opcode};
				end
				FMT_B: res.instruction_word = {off[12], off[10:5], it.rs2, it.rs1, e.funct3,
					off[4:1], off[11], e.opcode};
				FMT_J: res.instruction_word = {off[20], off[10:1], off[11], off[19:12], it.rd,
					e.opcode};
				FMT_U: res.instruction_word = {imm[19:0], it.rd, e.opcode};
				default: res.instruction_word = '0;
			endcase
		end
		return res;
	endfunction

	function automatic in_t make_item(input logic mode, input logic [4:0] mn,
			input logic [4:0] rd, input logic [4:0] rs1, input logic [4:0] rs2,
			input logic [31:0] imm, input logic known, input logic [31:0] target);
		in_t it;
		it.mode = mode;
		it.mnemonic = mn;
		it.rd = rd;
		it.rs1 = rs1;
		it.rs2 = rs2;
		it.imm = imm;
		it.target_known = known;
		it.target_address = target;
		return it;
	endfunction

	function automatic in_t random_item(input logic [31:0] at);
		in_t         it;
		int unsigned pick;
		logic [31:0] delta;
		it.mode = ($urandom_range(9) == 0) ? MODE_RAW : MODE_ENCODE;
		if ($urandom_range(24) == 0)
			it.mnemonic = 5'(MN_UNUSED0 + $urandom_range(1));
		else
			it.mnemonic = 5'($urandom_range(MN_COUNT - 1));
		it.rd = 5'($urandom_range(31));
		it.rs1 = 5'($urandom_range(31));
		it.rs2 = 5'($urandom_range(31));
		pick = $urandom_range(9);
		if (pick < 4)
			it.imm = $urandom_range(4199) - 2100;   // around the 12-bit boundary
		else if (pick < 6)
			it.imm = IMM_EDGES[3'($urandom_range(7))];
		else
			it.imm = $urandom;
		it.target_known = ($urandom_range(4) != 0);
		if ($urandom_range(1) == 0) begin
			delta = $urandom_range(8191);
			it.target_address = at + (delta << 1) - 32'd8192;
		end else
			it.target_address = $urandom;
		return it;
	endfunction

	task automatic push_item(input in_t it);
		pending_items.push_back(it);
		plan_address = plan_address + ADDR_STEP;
	endtask

	task automatic log_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// Item driver: valid holds until the transaction is taken, idle gaps are
	// decided only when the channel is free.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			encode_address = '0;
		end else begin
			if (item_valid && !item_stall) begin
				expected_results.push_back(encode_instruction(item, encode_address));
				encode_address = encode_address + ADDR_STEP;
			end
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else
					item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		out_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0)
					log_mismatch($sformatf("unexpected result word %h", result.instruction_word));
				else begin
					want = expected_results.pop_front();
					if (result.instruction_word !== want.instruction_word)
						log_mismatch($sformatf("instruction_word got %h want %h @%h",
							result.instruction_word, want.instruction_word,
							want.instruction_address));
					if (result.instruction_address !== want.instruction_address)
						log_mismatch($sformatf("instruction_address got %h want %h",
							result.instruction_address, want.instruction_address));
					if (result.needs_relocation !== want.needs_relocation)
						log_mismatch($sformatf("needs_relocation got %b want %b @%h",
							result.needs_relocation, want.needs_relocation,
							want.instruction_address));
					if (result.relocation_kind !== want.relocation_kind)
						log_mismatch($sformatf("relocation_kind got %b want %b @%h",
							result.relocation_kind, want.relocation_kind,
							want.instruction_address));
					if (result.imm_out_of_range !== want.imm_out_of_range)
						log_mismatch($sformatf("imm_out_of_range got %b want %b @%h",
							result.imm_out_of_range, want.imm_out_of_range,
							want.instruction_address));
				end
			end
			result_stall <= hold_results || ($urandom_range(99) < receiver_stall_pct);
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, each format, flags and unused codes
		push_item(make_item(MODE_ENCODE, MN_ADD, 5'd31, 5'd0, 5'd31, '0, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_SUB, 5'd0, 5'd31, 5'd0, '1, 1'b1, '1));
		push_item(make_item(MODE_ENCODE, MN_SRA, 5'd5, 5'd6, 5'd7, 32'h0000_0123, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_ADDI, 5'd1, 5'd2, 5'd3, 32'h0000_07FF, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_XORI, 5'd31, 5'd31, 5'd0, 32'hFFFF_F800, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_ORI, 5'd4, 5'd8, 5'd0, 32'h0000_0800, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_SLTI, 5'd9, 5'd10, 5'd0, 32'hFFFF_F7FF, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_SLLI, 5'd11, 5'd12, 5'd0, 32'h0000_0FFF, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_SRAI, 5'd13, 5'd14, 5'd0, 32'd31, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_SRLI, 5'd15, 5'd16, 5'd0, '1, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_LW, 5'd17, 5'd18, 5'd0, 32'h7FFF_FFFF, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_JALR, 5'd1, 5'd31, 5'd0, 32'h8000_0000, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_SB, 5'd0, 5'd2, 5'd31, '1, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_SW, 5'd0, 5'd3, 5'd4, 32'h0000_0800, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_BEQ, 5'd0, 5'd5, 5'd6, '0, 1'b1,
			plan_address - 32'd4096));
		push_item(make_item(MODE_ENCODE, MN_BGE, 5'd0, 5'd31, 5'd31, '0, 1'b1,
			plan_address + 32'd4094));
		push_item(make_item(MODE_ENCODE, MN_BNE, 5'd0, 5'd7, 5'd8, '0, 1'b0, 32'hDEAD_BEEF));
		push_item(make_item(MODE_ENCODE, MN_JAL, 5'd1, 5'd0, 5'd0, '0, 1'b1,
			plan_address + 32'h000F_FFFE));
		push_item(make_item(MODE_ENCODE, MN_JAL, 5'd31, 5'd0, 5'd0, '0, 1'b1, '0));
		push_item(make_item(MODE_ENCODE, MN_JAL, 5'd0, 5'd0, 5'd0, '0, 1'b0, 32'h0000_1000));
		push_item(make_item(MODE_ENCODE, MN_LUI, 5'd31, 5'd0, 5'd0, '1, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_AUIPC, 5'd2, 5'd0, 5'd0, 32'h0001_2345, 1'b0, '0));
		push_item(make_item(MODE_ENCODE, MN_UNUSED0, 5'd31, 5'd31, 5'd31, '1, 1'b0, '1));
		push_item(make_item(MODE_ENCODE, MN_UNUSED1, 5'd1, 5'd1, 5'd1, 32'h0000_0800, 1'b0, '0));
		push_item(make_item(MODE_RAW, MN_BNE, 5'd31, 5'd31, 5'd31, '1, 1'b0, '0));
		push_item(make_item(MODE_RAW, MN_JAL, 5'd0, 5'd0, 5'd0, '0, 1'b0, '1));
		wait_drained();

		// results held back long enough for the encoder to fill and stall its input
		fork
			begin
				hold_results = 1'b1;
				repeat (40) @(negedge clk);
				hold_results = 1'b0;
			end
		join_none
		repeat (30) push_item(random_item(plan_address));
		wait_drained();

		sender_idle_pct = 22;
		receiver_stall_pct = 51;
		repeat (440) push_item(random_item(plan_address));
		wait_drained();

		sender_idle_pct = 51;
		receiver_stall_pct = 22;
		repeat (440) push_item(random_item(plan_address));
		wait_drained();

		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		repeat (440) push_item(random_item(plan_address));
		wait_drained();

		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#1600000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rvie_pkg.sv
hdl/rvie_front.sv
hdl/rvie_queue.sv
hdl/rvie_back.sv
hdl/rv32i_instruction_encoder.sv
verif/tb_top.sv
